FILE: rtl/core/ppiu_pkg.sv
// shared types and helpers for the packed palette index unpacker
`timescale 1ns / 1ps

package ppiu_pkg;

  typedef enum logic [1:0] {
    ACT_BEGIN   = 2'd0,
    ACT_PALETTE = 2'd1,
    ACT_WORD    = 2'd2
  } action_e;

  localparam int unsigned CELL_POS_W = 13;
  localparam int unsigned CELL_LOC_W = 12;
  localparam int unsigned MAX_BITS   = 16;

  function automatic logic [4:0] sat_bits(input logic [4:0] bits);
    logic [4:0] b;
    b = bits;
    if (b == 5'd0) begin
      b = 5'd1;
    end else if (b > 5'(MAX_BITS)) begin
      b = 5'(MAX_BITS);
    end
    return b;
  endfunction

  // indices held by one 32-bit word
  function automatic logic [5:0] slots_per_word(input logic [4:0] bits);
    logic [5:0] n;
    unique case (bits)
      5'd1:    n = 6'd32;
      5'd2:    n = 6'd16;
      5'd3:    n = 6'd10;
      5'd4:    n = 6'd8;
      5'd5:    n = 6'd6;
      5'd6:    n = 6'd5;
      5'd7:    n = 6'd4;
      5'd8:    n = 6'd4;
      5'd9:    n = 6'd3;
      5'd10:   n = 6'd3;
      5'd11:   n = 6'd2;
      5'd12:   n = 6'd2;
      5'd13:   n = 6'd2;
      5'd14:   n = 6'd2;
      5'd15:   n = 6'd2;
      5'd16:   n = 6'd2;
      default: n = 6'd32;
    endcase
    return n;
  endfunction

  function automatic logic [15:0] index_mask(input logic [4:0] bits);
    logic [16:0] m;
    m = (17'h1 << bits) - 17'h1;
    return m[15:0];
  endfunction

endpackage

FILE: rtl/core/packed_palette_index_unpacker_unit.sv
// top level of the packed palette index unpacker
`timescale 1ns / 1ps

// Decodes one 16x16x16 voxel section stored as packed palette indices.
// Input channel (in_valid_i / in_stall_o): a begin word sets index width and
// section base and clears palette and cell position; a palette word appends a
// hash (ignored once the store is full); a data word is unpacked, lowest
// index first. Begin and palette words do not stall the input.
// A data word holds the input stalled while it is scanned: each index passes
// through the single palette memory read port in ST_SCAN (address), then in
// ST_LOOK (registered data and hit check), so a new data word is taken only
// once the previous one has been fully scanned and its last hit handed on.
// Cells outside the palette or with hash zero are skipped.
// Output channel (out_valid_o / out_stall_i): one word per emitted cell with
// world coordinates, hash and a last mark on the final cell of a data word.
// One hit is held back until the next hit or the end of the word so that the
// last mark is known.
// A receiver stall holds the output register and pauses the scan when a new
// hit has nowhere to go. Reset clears palette count, position, base and
// index width (one); palette memory contents are not cleared.
module packed_palette_index_unpacker_unit #(
  parameter int unsigned PALETTE_DEPTH = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [4:0]         bits_per_entry_i,
  input  logic signed [21:0] section_x_i,
  input  logic signed [21:0] section_y_i,
  input  logic signed [21:0] section_z_i,
  input  logic [31:0]        palette_hash_i,
  input  logic [31:0]        data_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [25:0] block_x_o,
  output logic signed [25:0] block_y_o,
  output logic signed [25:0] block_z_o,
  output logic [31:0]        block_hash_o,
  output logic               last_o
);

  localparam int unsigned AW   = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(PALETTE_DEPTH + 1);
  localparam int unsigned CMPW = (CNTW > ppiu_pkg::MAX_BITS) ? CNTW : ppiu_pkg::MAX_BITS;
  localparam int unsigned LOCW = ppiu_pkg::CELL_LOC_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOOK,
    ST_DONE
  } state_e;

  state_e state_q;

  logic [31:0] mem [PALETTE_DEPTH];
  logic [31:0] rd_data_q;

  logic [CNTW-1:0]                 count_q;
  logic [ppiu_pkg::CELL_POS_W-1:0] pos_q;
  logic [4:0]                      bits_q;
  logic signed [21:0]              base_x_q, base_y_q, base_z_q;
  logic [31:0]                     word_q;
  logic [5:0]                      left_q;
  logic                            range_q;
  logic [LOCW-1:0]                 cell_q;

  logic            held_valid_q;
  logic [LOCW-1:0] held_cell_q;
  logic [31:0]     held_hash_q;

  logic               out_valid_q;
  logic signed [25:0] out_x_q, out_y_q, out_z_q;
  logic [31:0]        out_hash_q;
  logic               out_last_q;

  logic            accept;
  logic            pal_we;
  logic            scan_more;
  logic            rd_en;
  logic [CMPW-1:0] idx_ext;
  logic            in_range;
  logic            hit;
  logic            out_free;
  logic            out_load;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign pal_we     = accept && (action_i == ppiu_pkg::ACT_PALETTE)
                      && (count_q < CNTW'(PALETTE_DEPTH));
  assign scan_more  = (left_q != 6'd0) && !pos_q[ppiu_pkg::CELL_POS_W-1];
  assign rd_en      = (state_q == ST_SCAN) && scan_more;
  assign idx_ext    = CMPW'(word_q[15:0] & ppiu_pkg::index_mask(bits_q));
  assign in_range   = idx_ext < CMPW'(count_q);
  assign hit        = range_q && (rd_data_q != 32'd0);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = out_free && held_valid_q
                      && (((state_q == ST_LOOK) && hit) || (state_q == ST_DONE));

  // palette memory
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      mem[count_q[AW-1:0]] <= palette_hash_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[idx_ext[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      pos_q        <= '0;
      bits_q       <= 5'd1;
      base_x_q     <= '0;
      base_y_q     <= '0;
      base_z_q     <= '0;
      word_q       <= '0;
      left_q       <= '0;
      range_q      <= 1'b0;
      cell_q       <= '0;
      held_valid_q <= 1'b0;
      held_cell_q  <= '0;
      held_hash_q  <= '0;
      out_valid_q  <= 1'b0;
      out_x_q      <= '0;
      out_y_q      <= '0;
      out_z_q      <= '0;
      out_hash_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            priority case (action_i)
              ppiu_pkg::ACT_BEGIN: begin
                bits_q   <= ppiu_pkg::sat_bits(bits_per_entry_i);
                base_x_q <= section_x_i;
                base_y_q <= section_y_i;
                base_z_q <= section_z_i;
                count_q  <= '0;
                pos_q    <= '0;
              end
              ppiu_pkg::ACT_PALETTE: begin
                if (pal_we) begin
                  count_q <= count_q + CNTW'(1);
                end
              end
              ppiu_pkg::ACT_WORD: begin
                word_q  <= data_word_i;
                left_q  <= ppiu_pkg::slots_per_word(bits_q);
                state_q <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_more) begin
            range_q <= in_range;
            cell_q  <= pos_q[LOCW-1:0];
            pos_q   <= pos_q + 13'd1;
            word_q  <= word_q >> bits_q;
            left_q  <= left_q - 6'd1;
            state_q <= ST_LOOK;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_LOOK: begin
          if (!hit) begin
            state_q <= ST_SCAN;
          end else if (!held_valid_q) begin
            held_valid_q <= 1'b1;
            held_cell_q  <= cell_q;
            held_hash_q  <= rd_data_q;
            state_q      <= ST_SCAN;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            out_x_q     <= {base_x_q, held_cell_q[11:8]};
            out_y_q     <= {base_y_q, held_cell_q[3:0]};
            out_z_q     <= {base_z_q, held_cell_q[7:4]};
            out_hash_q  <= held_hash_q;
            out_last_q  <= 1'b0;
            held_cell_q <= cell_q;
            held_hash_q <= rd_data_q;
            state_q     <= ST_SCAN;
          end
        end
        ST_DONE: begin
          if (!held_valid_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_valid_q  <= 1'b1;
            out_x_q      <= {base_x_q, held_cell_q[11:8]};
            out_y_q      <= {base_y_q, held_cell_q[3:0]};
            out_z_q      <= {base_z_q, held_cell_q[7:4]};
            out_hash_q   <= held_hash_q;
            out_last_q   <= 1'b1;
            held_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign block_x_o    = out_x_q;
  assign block_y_o    = out_y_q;
  assign block_z_o    = out_z_q;
  assign block_hash_o = out_hash_q;
  assign last_o       = out_last_q;

endmodule

FILE: rtl/core/ppiu_checker.sv
// port-level assertions for the packed palette index unpacker, with bind
`timescale 1ns / 1ps

module ppiu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  action_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] block_hash_o
);

  // output word holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(block_hash_o))
    else $error("stalled output hash changed");

  // skipped cells never leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> block_hash_o != 32'd0)
    else $error("zero hash emitted");

  // only a data word makes the input busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && (action_i == ppiu_pkg::ACT_WORD)))
    else $error("input busy without a data word");

endmodule

bind packed_palette_index_unpacker_unit ppiu_checker u_ppiu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .action_i     (action_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .block_hash_o (block_hash_o)
);
